// ===== rtl/core/ffa_pkg.sv =====
// Shared types and codes for the first-fit heap allocator.
`default_nettype none

package ffa_pkg;

  localparam logic [1:0] ACT_FORMAT = 2'd0;
  localparam logic [1:0] ACT_ALLOC  = 2'd1;
  localparam logic [1:0] ACT_FREE   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [12:0] ARENA_BYTES_RESET = 13'd4096;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FMT_END,
    S_HDR_EVAL,
    S_HDR_RD,
    S_MRG_RD,
    S_MRG_EVAL,
    S_SPLIT_TAIL,
    S_FREE_EVAL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FMT_FAIL,
    OP_FMT_HDR,
    OP_FMT_END,
    OP_ALLOC_FAIL,
    OP_NOFIT,
    OP_RD_HDR,
    OP_HDR_USED,
    OP_HDR_FREE,
    OP_RD_NX,
    OP_MERGE,
    OP_SKIP,
    OP_SPLIT_HDR,
    OP_SPLIT_TAIL,
    OP_WHOLE,
    OP_RD_FREE,
    OP_FREE_WR,
    OP_DONE0
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ffa_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       fmt_small;
    logic       req_big;
    logic       free_ok;
    logic       hdr_stop;
    logic       hdr_used;
    logic       mrg_go;
    logic       fits;
    logic       split_ok;
    logic       free_pos;
  } ffa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: controller plus datapath.
`default_nettype none

// A command is taken when start is high and busy is low; its one result appears
// on status, user_addr and block_words for a single cycle with done high, and
// must be captured then, as the block cannot be held off. A format writes the
// first header and then the end marker, or reports at once when the arena is
// too small; a free reads the header and writes it back as free if it is in use,
// or reports at once when its address is out of range; an unknown action and a
// refused allocate report from dispatch. An allocate reads the first header and
// every further header walked, and a neighbour header after a free block (one
// per merge and one more that ends the merge), and writes a tail header for a
// split. This is because the headers live in an arena memory with a registered
// read and each header must be read before the next address is known. A new
// command may be accepted in the cycle that carries the result. The arena
// contents are undefined until the first format; there is no clearing pass after
// reset. arena_bytes may be written whenever the block is idle.
module first_fit_heap_allocator_top #(
  parameter int ARENA_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [11:0] request_bytes,
  input  wire logic [9:0]  block_addr,
  output logic             done,
  output logic [1:0]       status,
  output logic [9:0]       user_addr,
  output logic [9:0]       block_words,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);
  import ffa_pkg::*;

  ffa_cmd_t  cmd;
  ffa_stat_t stat;

  assign cfg_ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffa_dp #(
    .ARENA_DEPTH (ARENA_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .action        (action),
    .request_bytes (request_bytes),
    .block_addr    (block_addr),
    .done          (done),
    .status        (status),
    .user_addr     (user_addr),
    .block_words   (block_words)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ffa_ctrl.sv =====
// Controller state machine that sequences format, allocate and free.
`default_nettype none

module ffa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ffa_pkg::ffa_stat_t stat,
  output ffa_pkg::ffa_cmd_t      cmd
);
  import ffa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.act)
          ACT_FORMAT: state_next = stat.fmt_small ? S_IDLE : S_FMT_END;
          ACT_ALLOC:  state_next = stat.req_big ? S_IDLE : S_HDR_EVAL;
          ACT_FREE:   state_next = stat.free_ok ? S_FREE_EVAL : S_IDLE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_FMT_END: state_next = S_IDLE;
      S_HDR_EVAL: begin
        if (stat.hdr_stop) state_next = S_IDLE;
        else if (stat.hdr_used) state_next = S_HDR_RD;
        else state_next = S_MRG_RD;
      end
      S_HDR_RD: state_next = S_HDR_EVAL;
      S_MRG_RD: state_next = S_MRG_EVAL;
      S_MRG_EVAL: begin
        if (stat.mrg_go) state_next = S_MRG_RD;
        else if (!stat.fits) state_next = S_HDR_RD;
        else if (stat.split_ok) state_next = S_SPLIT_TAIL;
        else state_next = S_IDLE;
      end
      S_SPLIT_TAIL: state_next = S_IDLE;
      S_FREE_EVAL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) cmd.op = OP_LOAD;
      end
      S_DISPATCH: begin
        unique case (stat.act)
          ACT_FORMAT: cmd.op = stat.fmt_small ? OP_FMT_FAIL : OP_FMT_HDR;
          ACT_ALLOC:  cmd.op = stat.req_big ? OP_ALLOC_FAIL : OP_RD_HDR;
          ACT_FREE:   cmd.op = stat.free_ok ? OP_RD_FREE : OP_DONE0;
          default:    cmd.op = OP_DONE0;
        endcase
      end
      S_FMT_END: cmd.op = OP_FMT_END;
      S_HDR_EVAL: begin
        if (stat.hdr_stop) cmd.op = OP_NOFIT;
        else if (stat.hdr_used) cmd.op = OP_HDR_USED;
        else cmd.op = OP_HDR_FREE;
      end
      S_HDR_RD: cmd.op = OP_RD_HDR;
      S_MRG_RD: cmd.op = OP_RD_NX;
      S_MRG_EVAL: begin
        if (stat.mrg_go) cmd.op = OP_MERGE;
        else if (!stat.fits) cmd.op = OP_SKIP;
        else if (stat.split_ok) cmd.op = OP_SPLIT_HDR;
        else cmd.op = OP_WHOLE;
      end
      S_SPLIT_TAIL: cmd.op = OP_SPLIT_TAIL;
      S_FREE_EVAL: cmd.op = stat.free_pos ? OP_FREE_WR : OP_DONE0;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffa_dp.sv =====
// Datapath: arena memory, walk registers, format arithmetic and result registers.
`default_nettype none

module ffa_dp #(
  parameter int ARENA_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ffa_pkg::ffa_cmd_t  cmd,
  output ffa_pkg::ffa_stat_t      stat,
  input  wire logic               cfg_valid,
  input  wire logic [12:0]        cfg_data,
  input  wire logic [1:0]         action,
  input  wire logic [11:0]        request_bytes,
  input  wire logic [9:0]         block_addr,
  output logic                    done,
  output logic [1:0]              status,
  output logic [9:0]              user_addr,
  output logic [9:0]              block_words
);
  import ffa_pkg::*;

  localparam int AW = $clog2(ARENA_DEPTH);
  localparam int DW = AW + 1;
  localparam int SW = AW + 2;
  localparam int CW = ((AW > 11) ? AW : 11) + 2;
  localparam logic [12:0] CapBytes =
    13'((4 * ARENA_DEPTH > 8191) ? 8191 : 4 * ARENA_DEPTH);

  // Headers are signed sizes: negative free, positive used, zero ends the arena.
  logic [DW-1:0] mem [ARENA_DEPTH];
  logic [DW-1:0] rd_data;

  logic [12:0] arena_bytes;
  logic [12:0] fmt_bytes;
  logic [1:0]  act;
  logic [11:0] req_q;
  logic [9:0]  addr_q;
  logic [10:0] need;
  logic [AW-1:0] p;
  logic [AW-1:0] m;
  logic [AW-1:0] nx;
  logic [AW-1:0] fmt_n;

  logic [12:0]   b_eff;
  logic [AW-1:0] n_calc;
  logic [12:0]   req_up;
  logic [10:0]   need_calc;
  logic [DW-1:0] s_mag;
  logic [SW-1:0] nx_h;
  logic [SW-1:0] nn;
  logic [AW-1:0] m_sum;
  logic [AW-1:0] h;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [DW-1:0] wdata;

  always_comb begin
    b_eff     = (arena_bytes > CapBytes) ? CapBytes : arena_bytes;
    n_calc    = AW'((b_eff - 13'd9) >> 2);
    req_up    = {1'b0, request_bytes} + 13'd3;
    need_calc = 11'(req_up >> 2);
    if (need_calc == 11'd0) need_calc = 11'd1;
    s_mag = rd_data[DW-1] ? (DW'(0) - rd_data) : rd_data;
    nx_h  = SW'(p) + SW'(s_mag) + SW'(1);
    nn    = SW'(nx) + SW'(s_mag) + SW'(1);
    m_sum = AW'(SW'(m) + SW'(s_mag) + SW'(1));
    h     = AW'(addr_q - 10'd1);
  end

  always_comb begin
    stat.act       = act;
    stat.fmt_small = (b_eff < 13'd16);
    stat.req_big   = (fmt_bytes <= {1'b0, req_q});
    stat.free_ok   = (addr_q >= 10'd2) && ((CW'(addr_q) - CW'(1)) < CW'(ARENA_DEPTH));
    stat.hdr_stop  = (rd_data == DW'(0)) || (s_mag >= DW'(ARENA_DEPTH)) ||
                     (nx_h >= SW'(ARENA_DEPTH));
    stat.hdr_used  = !rd_data[DW-1];
    stat.mrg_go    = rd_data[DW-1] && (s_mag < DW'(ARENA_DEPTH)) &&
                     (nn < SW'(ARENA_DEPTH));
    stat.fits      = (CW'(m) >= CW'(need));
    stat.split_ok  = (CW'(m) >= CW'(need) + CW'(2));
    stat.free_pos  = !rd_data[DW-1] && (rd_data != DW'(0));
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = p;
    raddr = p;
    wdata = DW'(0);
    case (cmd.op)
      OP_FMT_HDR: begin
        we    = 1'b1;
        waddr = AW'(1);
        wdata = DW'(0) - DW'(n_calc);
      end
      OP_FMT_END: begin
        we    = 1'b1;
        waddr = fmt_n + AW'(2);
      end
      OP_RD_HDR: re = 1'b1;
      OP_RD_NX: begin
        re    = 1'b1;
        raddr = nx;
      end
      OP_RD_FREE: begin
        re    = 1'b1;
        raddr = h;
      end
      OP_MERGE: begin
        we    = 1'b1;
        wdata = DW'(0) - DW'(m_sum);
      end
      OP_SPLIT_HDR: begin
        we    = 1'b1;
        wdata = DW'(need);
      end
      OP_SPLIT_TAIL: begin
        we    = 1'b1;
        waddr = p + AW'(need) + AW'(1);
        wdata = DW'(0) - DW'(m - AW'(need) - AW'(1));
      end
      OP_WHOLE: begin
        we    = 1'b1;
        wdata = DW'(m);
      end
      OP_FREE_WR: begin
        we    = 1'b1;
        waddr = h;
        wdata = DW'(0) - rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes <= ARENA_BYTES_RESET;
      fmt_bytes   <= 13'd0;
      done        <= 1'b0;
    end else begin
      if (cfg_valid) arena_bytes <= cfg_data;
      if (cmd.op == OP_FMT_FAIL) fmt_bytes <= 13'd0;
      if (cmd.op == OP_FMT_HDR) fmt_bytes <= b_eff;
      done <= (cmd.op == OP_FMT_FAIL) || (cmd.op == OP_FMT_END) ||
              (cmd.op == OP_ALLOC_FAIL) || (cmd.op == OP_NOFIT) ||
              (cmd.op == OP_SPLIT_TAIL) || (cmd.op == OP_WHOLE) ||
              (cmd.op == OP_FREE_WR) || (cmd.op == OP_DONE0);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act    <= action;
        req_q  <= request_bytes;
        addr_q <= block_addr;
        need   <= need_calc;
        p      <= AW'(1);
      end
      OP_FMT_HDR: fmt_n <= n_calc;
      OP_HDR_USED: p <= AW'(nx_h);
      OP_HDR_FREE: begin
        m  <= AW'(s_mag);
        nx <= AW'(nx_h);
      end
      OP_MERGE: begin
        m  <= m_sum;
        nx <= AW'(nn);
      end
      OP_SKIP: p <= nx;
      default: ;
    endcase

    case (cmd.op)
      OP_FMT_FAIL, OP_ALLOC_FAIL: begin
        status      <= ST_RANGE;
        user_addr   <= 10'd0;
        block_words <= 10'd0;
      end
      OP_NOFIT: begin
        status      <= ST_NOFIT;
        user_addr   <= 10'd0;
        block_words <= 10'd0;
      end
      OP_FMT_END: begin
        status      <= ST_OK;
        user_addr   <= 10'd0;
        block_words <= 10'(fmt_n);
      end
      OP_SPLIT_TAIL: begin
        status      <= ST_OK;
        user_addr   <= 10'(SW'(p) + SW'(1));
        block_words <= 10'(need);
      end
      OP_WHOLE: begin
        status      <= ST_OK;
        user_addr   <= 10'(SW'(p) + SW'(1));
        block_words <= 10'(m);
      end
      OP_FREE_WR, OP_DONE0: begin
        status      <= ST_OK;
        user_addr   <= 10'd0;
        block_words <= 10'd0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffa_checker.sv =====
// Port-level checks on the allocator, bound to the top level.
`default_nettype none

module ffa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [9:0] user_addr,
  input wire logic [9:0] block_words
);
  import ffa_pkg::*;

  // A result only ever closes a command that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not make the block busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == ST_OK) || (status == ST_NOFIT) || (status == ST_RANGE)))
    else $error("undefined status code");

  // Failed commands report zero address and size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((user_addr == 10'd0) && (block_words == 10'd0)))
    else $error("failed command reported an address or size");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_chk (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the first-fit heap allocator, driving directed then random commands.
import ffa_pkg::*;

localparam int HEAP_DEPTH = 1024;

typedef struct packed {
  logic [1:0] status;
  logic [9:0] user_addr;
  logic [9:0] block_words;
} heap_reply_t;

class heap_scoreboard;
  int          arena [HEAP_DEPTH];
  bit          touched [HEAP_DEPTH];
  int unsigned fmt_bytes;
  int unsigned arena_bytes;
  int          live_blocks [$];
  heap_reply_t awaited_results [$];
  int          mismatches;
  int          checked;
  int          formats, grants, no_fits, refusals, frees, size_writes;

  function new();
    fmt_bytes = 0;
    arena_bytes = ARENA_BYTES_RESET;
  endfunction

  function void note_arena_bytes(logic [12:0] value);
    arena_bytes = value;
    size_writes++;
  endfunction

  // Works out the reply to one command and updates the shadow arena.
  function heap_reply_t compute_heap_reply(logic [1:0] act, logic [11:0] req,
                                           logic [9:0] addr);
    heap_reply_t r;
    int b, n, need, p, s, m, nx, m2, h;
    r = '0;
    r.status = ST_OK;
    if (act == ACT_FORMAT) begin
      b = (arena_bytes > 4 * HEAP_DEPTH) ? 4 * HEAP_DEPTH : arena_bytes;
      if (b < 16) begin
        fmt_bytes = 0;
        r.status = ST_RANGE;
      end else begin
        n = (b - 9) / 4;
        arena[1] = -n;
        arena[n + 2] = 0;
        touched[1] = 1'b1;
        touched[n + 2] = 1'b1;
        fmt_bytes = b;
        r.block_words = 10'(n);
        live_blocks.delete();
      end
    end else if (act == ACT_ALLOC) begin
      if (fmt_bytes <= req) begin
        r.status = ST_RANGE;
      end else begin
        need = (req + 3) / 4;
        if (need == 0) need = 1;
        r.status = ST_NOFIT;
        p = 1;
        while (p < HEAP_DEPTH) begin
          s = arena[p];
          m = (s < 0) ? -s : s;
          if (s == 0 || m >= HEAP_DEPTH || p + m + 1 >= HEAP_DEPTH) break;
          nx = p + m + 1;
          if (s > 0) begin
            p = nx;
            continue;
          end
          // Absorb every free block that follows, stopping at one that overruns.
          while (arena[nx] < 0) begin
            m2 = -arena[nx];
            if (m2 >= HEAP_DEPTH || nx + m2 + 1 >= HEAP_DEPTH) break;
            m = m + m2 + 1;
            arena[p] = -m;
            nx = nx + m2 + 1;
          end
          if (m < need) begin
            p = nx;
            continue;
          end
          r.status = ST_OK;
          r.user_addr = 10'(p + 1);
          if (m - need >= 2) begin
            arena[p] = need;
            arena[p + need + 1] = -(m - need - 1);
            touched[p + need + 1] = 1'b1;
            r.block_words = 10'(need);
          end else begin
            arena[p] = m;
            r.block_words = 10'(m);
          end
          live_blocks.push_back(p + 1);
          break;
        end
      end
    end else if (act == ACT_FREE) begin
      if (addr >= 2) begin
        h = addr - 1;
        if (arena[h] > 0) arena[h] = -arena[h];
        foreach (live_blocks[i])
          if (live_blocks[i] == addr) begin
            live_blocks.delete(i);
            break;
          end
      end
    end
    return r;
  endfunction

  function void note_command(logic [1:0] act, logic [11:0] req, logic [9:0] addr);
    heap_reply_t r;
    r = compute_heap_reply(act, req, addr);
    awaited_results.push_back(r);
    if (act == ACT_FORMAT) formats++;
    if (act == ACT_FREE) frees++;
    if (act == ACT_ALLOC) begin
      if (r.status == ST_OK) grants++;
      else if (r.status == ST_NOFIT) no_fits++;
      else refusals++;
    end
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch: %s", what);
  endfunction

  function void check_result(logic [1:0] st, logic [9:0] ua, logic [9:0] bw);
    heap_reply_t want;
    if (awaited_results.size() == 0) begin
      flag($sformatf("result with nothing awaited: status %0d addr %0d words %0d",
                     st, ua, bw));
      return;
    end
    want = awaited_results.pop_front();
    checked++;
    if (st !== want.status || ua !== want.user_addr || bw !== want.block_words)
      flag($sformatf("expected status %0d addr %0d words %0d, got status %0d addr %0d words %0d",
                     want.status, want.user_addr, want.block_words, st, ua, bw));
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_NONE = 2'd3;
  localparam int          ITEMS_PER_PHASE = 642;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = ACT_FORMAT;
  logic [11:0] request_bytes = '0;
  logic [9:0]  block_addr = '0;
  logic        cfg_valid = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [9:0]  user_addr;
  logic [9:0]  block_words;
  logic        cfg_ready;

  heap_scoreboard sb;
  int             idle_pct = 0;
  int unsigned    cycles = 0;

  first_fit_heap_allocator_top #(.ARENA_DEPTH(HEAP_DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .request_bytes(request_bytes), .block_addr(block_addr),
    .done(done), .status(status), .user_addr(user_addr), .block_words(block_words),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", cycles);
      $display("FAIL first_fit_heap_allocator_top");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done) sb.check_result(status, user_addr, block_words);

  // Presents one item, possibly after an idle gap, and returns at the edge that takes it.
  task automatic issue(input logic [1:0] act, input logic [11:0] req, input logic [9:0] addr);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    request_bytes <= req;
    block_addr <= addr;
    do @(posedge clk); while (busy);
    sb.note_command(act, req, addr);
  endtask

  // Waits on the falling edge so that the check at the rising edge has already run.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.awaited_results.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_arena_bytes(input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.note_arena_bytes(value);
  endtask

  // Returns an address whose header word has been written, or one below 2 that is out of range.
  function automatic logic [9:0] touched_addr();
    int a;
    repeat (32) begin
      a = $urandom_range(0, HEAP_DEPTH - 1);
      if (a < 2 || sb.touched[a - 1]) return a[9:0];
    end
    return 10'($urandom_range(0, 1));
  endfunction

  initial begin
    int          placed, sel, span;
    logic [12:0] nb;
    logic [11:0] req;
    logic [9:0]  fa;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Before any format: allocations are refused and stray frees are ignored.
    issue(ACT_ALLOC, 12'd0, 10'd0);
    issue(ACT_NONE, 12'hfff, 10'h3ff);
    issue(ACT_FREE, 12'd0, 10'd0);
    issue(ACT_FREE, 12'hfff, 10'd1);
    drain();
    write_arena_bytes(13'd0);
    issue(ACT_FORMAT, 12'd0, 10'd0);
    drain();
    write_arena_bytes(13'd15);
    issue(ACT_FORMAT, 12'd0, 10'd0);
    issue(ACT_ALLOC, 12'd0, 10'd0);
    // Smallest arena: a single one-word block.
    drain();
    write_arena_bytes(13'd16);
    issue(ACT_FORMAT, 12'd0, 10'd0);
    issue(ACT_ALLOC, 12'd0, 10'd0);
    issue(ACT_ALLOC, 12'd0, 10'd0);
    issue(ACT_FREE, 12'd0, 10'd2);
    issue(ACT_ALLOC, 12'd4, 10'd0);
    issue(ACT_ALLOC, 12'd16, 10'd0);
    // Two-word block: a one-word request takes it whole, then double free and end marker.
    drain();
    write_arena_bytes(13'd20);
    issue(ACT_FORMAT, 12'd0, 10'd0);
    issue(ACT_ALLOC, 12'd1, 10'd0);
    issue(ACT_FREE, 12'd0, 10'd2);
    issue(ACT_FREE, 12'd0, 10'd2);
    issue(ACT_FREE, 12'd0, 10'd5);
    // Oversized register value is clamped to the full arena; splits then a full merge.
    drain();
    write_arena_bytes(13'h1fff);
    issue(ACT_FORMAT, 12'd0, 10'd0);
    issue(ACT_ALLOC, 12'd4095, 10'd0);
    issue(ACT_ALLOC, 12'd2048, 10'd0);
    issue(ACT_ALLOC, 12'd8, 10'd0);
    issue(ACT_FREE, 12'd0, 10'd2);
    issue(ACT_FREE, 12'd0, 10'd515);
    issue(ACT_ALLOC, 12'd4092, 10'd0);
    issue(ACT_ALLOC, 12'd4084, 10'd0);
    issue(ACT_FREE, 12'd0, 10'd2);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
      placed = 0;
      while (placed < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          drain();
          sel = $urandom_range(0, 9);
          if (sel < 3) nb = 13'd4096;
          else if (sel < 6) nb = 13'($urandom_range(64, 512));
          else if (sel < 8) nb = 13'($urandom_range(16, 63));
          else if (sel < 9) nb = 13'($urandom_range(513, 4095));
          else if ($urandom_range(0, 1) == 0) nb = 13'($urandom_range(0, 15));
          else nb = 13'($urandom_range(4097, 8191));
          write_arena_bytes(nb);
        end
        issue(ACT_FORMAT, 12'($urandom), 10'($urandom));
        placed++;
        span = $urandom_range(20, 120);
        for (int k = 0; k < span && placed < ITEMS_PER_PHASE; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 55) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) req = 12'($urandom_range(0, 32));
            else if (sel < 85) req = 12'($urandom_range(0, 400));
            else if (sel < 95) req = 12'($urandom_range(0, 4095));
            else if (sb.fmt_bytes == 0) req = 12'd0;
            else if (sb.fmt_bytes > 4095) req = 12'd4095;
            else req = 12'(sb.fmt_bytes - $urandom_range(0, 1));
            issue(ACT_ALLOC, req, 10'($urandom));
            placed++;
          end else if (sel < 92) begin
            if (sb.live_blocks.size() != 0)
              fa = 10'(sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
            else
              fa = touched_addr();
            issue(ACT_FREE, 12'($urandom), fa);
            placed++;
          end else if (sel < 96) begin
            issue(ACT_FREE, 12'($urandom), touched_addr());
            placed++;
          end else if (sel < 98) begin
            issue(ACT_NONE, 12'($urandom), 10'($urandom));
          end else begin
            issue(ACT_FORMAT, 12'($urandom), 10'($urandom));
            placed++;
          end
        end
      end
    end

    drain();
    repeat (64) @(posedge clk);
    $display("Covered %0d formats, %0d grants, %0d no-fits, %0d refused allocations,",
             sb.formats, sb.grants, sb.no_fits, sb.refusals);
    $display("%0d frees and %0d arena size writes; %0d results checked, %0d mismatched.",
             sb.frees, sb.size_writes, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("PASS first_fit_heap_allocator_top");
    end else begin
      $display("FAIL first_fit_heap_allocator_top");
    end
    $finish;
  end
endmodule
